>>> hdl/twfm_pkg.sv
// ----------------------------------------------------------------------------
// twfm_pkg: shared constants of the timed window fault monitor
// Field widths, pedal thresholds and the default channel count.
// ----------------------------------------------------------------------------
`default_nettype none

package twfm_pkg;

   localparam int CHANNEL_W   = 3;
   localparam int SAMPLE_W    = 16;
   localparam int LIMIT_W     = 16;
   localparam int PRESSURE_W  = 16;
   localparam int PEDAL_W     = 7;

   localparam int NUM_CHANNELS_DEF = 8;

   // Pedal thresholds in whole percent
   localparam logic [PEDAL_W-1:0] PEDAL_SET_PCT   = 7'd25;
   localparam logic [PEDAL_W-1:0] PEDAL_CLEAR_PCT = 7'd5;

endpackage : twfm_pkg

`default_nettype wire

>>> hdl/timed_window_fault_monitor.sv
// Path: an accepted request beat passes the input register, then the result
//   register, on its way to its response beat.
// Throughput: one beat per cycle while the response side is not stalled; the
//   single-pass update of one channel's counter and trip flag sets the pace.
// Reset: synchronous, active high; clears all counters, trip flags, the
//   plausibility latch, the brake limit register and both valid flags.
// ----------------------------------------------------------------------------
// timed_window_fault_monitor
// Persistence-filtered window comparator per channel, with a brake/pedal
// plausibility latch and a combined vehicle fault output.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_window_fault_monitor #(
   parameter int NUM_CHANNELS = twfm_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // configuration: brake pressure limit
   input  wire logic                                    csr_wr_en,
   input  wire logic        [twfm_pkg::PRESSURE_W-1:0]  csr_wr_data,
   // request channel
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic        [twfm_pkg::CHANNEL_W-1:0]   req_channel,
   input  wire logic signed [twfm_pkg::SAMPLE_W-1:0]    req_sample,
   input  wire logic signed [twfm_pkg::SAMPLE_W-1:0]    req_window_low,
   input  wire logic signed [twfm_pkg::SAMPLE_W-1:0]    req_window_high,
   input  wire logic        [twfm_pkg::LIMIT_W-1:0]     req_persist_limit,
   input  wire logic                                    req_ext_input_fault,
   input  wire logic        [twfm_pkg::PRESSURE_W-1:0]  req_brake_pressure,
   input  wire logic        [twfm_pkg::PEDAL_W-1:0]     req_pedal_percent,
   // response channel
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic                                         rsp_channel_tripped,
   output logic                                         rsp_vehicle_fault,
   output logic                                         rsp_plausibility_latched
);

   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   // wide enough to hold any channel code and NUM_CHANNELS values up to 63
   localparam int CH_EXT_W = 6;

   // -------------------------------------------------------------------------
   // Handshake: the input register drains into the result register whenever
   // the result register is empty or its beat is being taken this cycle.
   // -------------------------------------------------------------------------
   logic in_valid_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic advance;
   logic req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // -------------------------------------------------------------------------
   // Input register (payload, no reset)
   // -------------------------------------------------------------------------
   logic        [twfm_pkg::CHANNEL_W-1:0]  channel_ff;
   logic signed [twfm_pkg::SAMPLE_W-1:0]   sample_ff;
   logic signed [twfm_pkg::SAMPLE_W-1:0]   window_low_ff;
   logic signed [twfm_pkg::SAMPLE_W-1:0]   window_high_ff;
   logic        [twfm_pkg::LIMIT_W-1:0]    persist_limit_ff;
   logic                                   ext_fault_ff;
   logic        [twfm_pkg::PRESSURE_W-1:0] brake_pressure_ff;
   logic        [twfm_pkg::PEDAL_W-1:0]    pedal_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         channel_ff        <= req_channel;
         sample_ff         <= req_sample;
         window_low_ff     <= req_window_low;
         window_high_ff    <= req_window_high;
         persist_limit_ff  <= req_persist_limit;
         ext_fault_ff      <= req_ext_input_fault;
         brake_pressure_ff <= req_brake_pressure;
         pedal_ff          <= req_pedal_percent;
      end
   end

   // -------------------------------------------------------------------------
   // Channel state and the plausibility latch
   // -------------------------------------------------------------------------
   logic [twfm_pkg::LIMIT_W-1:0]    count_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]         trip_ff;
   logic                            latch_ff;
   logic [twfm_pkg::PRESSURE_W-1:0] brake_limit_ff;

   // -------------------------------------------------------------------------
   // Single-pass update of the addressed channel
   // -------------------------------------------------------------------------
   logic [CH_EXT_W-1:0]          ch_ext;
   logic                         ch_valid;
   logic [CH_IDX_W-1:0]          ch_idx;
   logic                         in_window;
   logic [twfm_pkg::LIMIT_W-1:0] count_cur;
   logic [twfm_pkg::LIMIT_W:0]   count_inc;
   logic [twfm_pkg::LIMIT_W:0]   limit_p1;
   logic [twfm_pkg::LIMIT_W:0]   count_held;
   logic [twfm_pkg::LIMIT_W-1:0] count_in;
   logic                         trip_hit;
   logic [NUM_CHANNELS-1:0]      trip_in;
   logic                         latch_in;

   assign ch_ext    = {{(CH_EXT_W - twfm_pkg::CHANNEL_W){1'b0}}, channel_ff};
   assign ch_valid  = (ch_ext < CH_EXT_W'(NUM_CHANNELS));
   assign ch_idx    = ch_ext[CH_IDX_W-1:0];
   assign in_window = (sample_ff >= window_low_ff) && (sample_ff <= window_high_ff);
   assign count_cur = ch_valid ? count_ff[ch_idx] : '0;

   always_comb begin
      count_inc = {1'b0, count_cur} + 1'b1;
      limit_p1  = {1'b0, persist_limit_ff} + 1'b1;
      // hold the counter at limit + 1, and never above the counter's range
      count_held = (count_inc > {1'b0, persist_limit_ff}) ? limit_p1 : count_inc;
      if (count_held[twfm_pkg::LIMIT_W]) begin
         count_in = '1;
      end else begin
         count_in = count_held[twfm_pkg::LIMIT_W-1:0];
      end
      trip_hit = (count_in > persist_limit_ff);
      if (in_window) begin
         count_in = '0;
      end
   end

   always_comb begin
      trip_in = trip_ff;
      if (ch_valid) begin
         if (in_window) begin
            trip_in[ch_idx] = 1'b0;
         end else if (trip_hit) begin
            trip_in[ch_idx] = 1'b1;
         end
      end
   end

   // set on a hard brake with the pedal pressed, drop once the pedal is released
   always_comb begin
      latch_in = latch_ff;
      if ((brake_pressure_ff > brake_limit_ff) && (pedal_ff > twfm_pkg::PEDAL_SET_PCT)) begin
         latch_in = 1'b1;
      end else if (pedal_ff <= twfm_pkg::PEDAL_CLEAR_PCT) begin
         latch_in = 1'b0;
      end
   end

   // -------------------------------------------------------------------------
   // State registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            count_ff[i] <= '0;
         end
         trip_ff        <= '0;
         latch_ff       <= 1'b0;
         brake_limit_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            brake_limit_ff <= csr_wr_data;
         end
         if (advance) begin
            if (ch_valid) begin
               count_ff[ch_idx] <= count_in;
            end
            trip_ff  <= trip_in;
            latch_ff <= latch_in;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Valid flags and the result register
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   logic channel_tripped_ff;
   logic vehicle_fault_ff;
   logic plaus_latched_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         channel_tripped_ff <= ch_valid && trip_in[ch_idx];
         vehicle_fault_ff   <= (|trip_in) || latch_in || ext_fault_ff;
         plaus_latched_ff   <= latch_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_channel_tripped      = channel_tripped_ff;
   assign rsp_vehicle_fault        = vehicle_fault_ff;
   assign rsp_plausibility_latched = plaus_latched_ff;

endmodule : timed_window_fault_monitor

`default_nettype wire

>>> hdl/twfm_checker.sv
// ----------------------------------------------------------------------------
// twfm_checker: port-level checks of the timed window fault monitor
// Watches the handshakes and the response beat's fault flags.
// ----------------------------------------------------------------------------
`default_nettype none

module twfm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_channel_tripped,
   input wire logic rsp_vehicle_fault,
   input wire logic rsp_plausibility_latched
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_channel_tripped)
         && $stable(rsp_vehicle_fault) && $stable(rsp_plausibility_latched))
      else $error("response beat changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a tripped channel is part of the vehicle fault
   a_trip_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel_tripped |-> rsp_vehicle_fault)
      else $error("channel trip without vehicle fault");

   // the plausibility latch is part of the vehicle fault
   a_latch_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_plausibility_latched |-> rsp_vehicle_fault)
      else $error("plausibility latch without vehicle fault");

   // a request accepted into an empty block appears via the result register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid && !req_stall ##1 !rsp_stall
         |=> rsp_valid)
      else $error("response beat missing");

endmodule : twfm_checker

bind timed_window_fault_monitor twfm_checker u_twfm_checker (
   .clock                    (clock),
   .reset                    (reset),
   .req_valid                (req_valid),
   .req_stall                (req_stall),
   .rsp_valid                (rsp_valid),
   .rsp_stall                (rsp_stall),
   .rsp_channel_tripped      (rsp_channel_tripped),
   .rsp_vehicle_fault        (rsp_vehicle_fault),
   .rsp_plausibility_latched (rsp_plausibility_latched)
);

`default_nettype wire
